/* hdl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// msd_pkg
// Types, codes and constants shared by the magic-sync message deframer.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int MAGIC_BYTES  = 4;
  localparam int HDR_CNT_W    = 5;
  localparam int CFG_INDEX_W  = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

  // Header byte positions, counted from the first magic byte
  localparam logic [HDR_CNT_W-1:0] CNT_MAGIC    = HDR_CNT_W'(MAGIC_BYTES);
  localparam logic [HDR_CNT_W-1:0] CNT_TYPE_END = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] CNT_LEN_END  = HDR_CNT_W'(12);
  localparam logic [HDR_CNT_W-1:0] CNT_SEQ_END  = HDR_CNT_W'(16);
  localparam logic [HDR_CNT_W-1:0] CNT_HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic        is_header;
    logic [31:0] msg_type;
    logic [31:0] sequence_number;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic        checksum_ok;
  } result_t;

endpackage

/* hdl/msd_ifs.sv */
// ----------------------------------------------------------------------------
// msd_ifs
// Valid/ready channels of the deframer: byte stream, results and config.
// ----------------------------------------------------------------------------
interface msd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface msd_result_if;
  logic        valid;
  logic        ready;
  logic        is_header;
  logic [31:0] msg_type;
  logic [31:0] sequence_number;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;
  logic        checksum_ok;

  modport source (
    output valid, output is_header, output msg_type, output sequence_number,
    output payload_length, output payload_byte, output last, output checksum_ok,
    input ready
  );
  modport sink (
    input valid, input is_header, input msg_type, input sequence_number,
    input payload_length, input payload_byte, input last, input checksum_ok,
    output ready
  );
endinterface

interface msd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [msd_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/msd_front.sv */
// ----------------------------------------------------------------------------
// msd_front
// Byte parser: magic hunt, header capture, length check and payload
// streaming with running checksum. Pushes one result per result beat.
// ----------------------------------------------------------------------------
module msd_front (
  input  logic             clk,
  input  logic             rst,
  msd_cfg_if.sink          cfg,
  msd_byte_if.sink         stream,
  input  logic             queue_full,
  output logic             push,
  output msd_pkg::result_t push_data
);

  logic [31:0] magic_word;
  logic [31:0] max_payload_length;

  msd_pkg::phase_t               phase;
  msd_pkg::phase_t               phase_next;
  logic [31:0]                   sync_window;
  logic [msd_pkg::HDR_CNT_W-1:0] header_byte_count;

  logic [31:0] held_type;
  logic [31:0] held_length;
  logic [31:0] held_sequence;
  logic [31:0] held_checksum;
  logic [31:0] running_sum;
  logic [31:0] bytes_remaining;

  logic                          acc;
  logic [7:0]                    b;
  logic [31:0]                   window_shift;
  logic [msd_pkg::HDR_CNT_W-1:0] count_sat;
  logic                          magic_hit;
  logic                          hdr_done;
  logic [31:0]                   checksum_shift;
  logic                          oversize;
  logic                          empty_msg;
  logic [31:0]                   sum_shift;
  logic                          pay_last;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word         <= '0;
      max_payload_length <= msd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == msd_pkg::CFG_MAGIC_WORD) begin
        magic_word <= cfg.data;
      end else if (cfg.index == msd_pkg::CFG_MAX_PAYLOAD) begin
        max_payload_length <= cfg.data;
      end
    end
  end

  assign acc            = stream.valid && stream.ready;
  assign b              = stream.data_byte;
  assign window_shift   = {sync_window[23:0], b};
  assign count_sat      = (header_byte_count < msd_pkg::CNT_MAGIC) ?
                          header_byte_count + 1'b1 : header_byte_count;
  // count saturates at the magic length, so equality means the window is full
  assign magic_hit      = (count_sat == msd_pkg::CNT_MAGIC) && (window_shift == magic_word);
  assign hdr_done       = header_byte_count == msd_pkg::CNT_HDR_LAST;
  assign checksum_shift = {held_checksum[23:0], b};
  assign oversize       = held_length > max_payload_length;
  assign empty_msg      = held_length == '0;
  assign sum_shift      = running_sum + {24'd0, b};
  assign pay_last       = bytes_remaining == 32'd1;

  // Next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      msd_pkg::PH_HUNT: begin
        if (acc && magic_hit) phase_next = msd_pkg::PH_HEADER;
      end
      msd_pkg::PH_HEADER: begin
        if (acc && hdr_done) begin
          phase_next = (oversize || empty_msg) ? msd_pkg::PH_HUNT : msd_pkg::PH_PAYLOAD;
        end
      end
      msd_pkg::PH_PAYLOAD: begin
        if (acc && pay_last) phase_next = msd_pkg::PH_HUNT;
      end
      default: phase_next = msd_pkg::PH_HUNT;
    endcase
  end

  // Outputs
  always_comb begin
    push                           = 1'b0;
    push_data                      = '0;
    push_data.msg_type             = held_type;
    push_data.sequence_number      = held_sequence;
    push_data.payload_length       = held_length;
    unique case (phase)
      msd_pkg::PH_HEADER: begin
        if (acc && hdr_done && !oversize) begin
          push                  = 1'b1;
          push_data.is_header   = 1'b1;
          push_data.last        = empty_msg;
          push_data.checksum_ok = empty_msg && (checksum_shift == '0);
        end
      end
      msd_pkg::PH_PAYLOAD: begin
        if (acc) begin
          push                   = 1'b1;
          push_data.payload_byte = b;
          push_data.last         = pay_last;
          push_data.checksum_ok  = pay_last && (sum_shift == held_checksum);
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= msd_pkg::PH_HUNT;
      sync_window       <= '0;
      header_byte_count <= '0;
    end else begin
      phase <= phase_next;
      if (acc) begin
        unique case (phase)
          msd_pkg::PH_HUNT: begin
            sync_window       <= window_shift;
            header_byte_count <= count_sat;
          end
          msd_pkg::PH_HEADER: begin
            if (hdr_done) begin
              sync_window       <= '0;
              header_byte_count <= '0;
            end else begin
              header_byte_count <= header_byte_count + 1'b1;
            end
          end
          msd_pkg::PH_PAYLOAD: begin
            if (pay_last) begin
              sync_window       <= '0;
              header_byte_count <= '0;
            end
          end
          default: begin
            sync_window       <= '0;
            header_byte_count <= '0;
          end
        endcase
      end
    end
  end

  // Header words and payload counters; the four header words are fully
  // overwritten by their four bytes each, so no clearing on sync
  always_ff @(posedge clk) begin
    if (acc) begin
      if (phase == msd_pkg::PH_HEADER) begin
        if (header_byte_count < msd_pkg::CNT_TYPE_END) begin
          held_type <= {held_type[23:0], b};
        end else if (header_byte_count < msd_pkg::CNT_LEN_END) begin
          held_length <= {held_length[23:0], b};
        end else if (header_byte_count < msd_pkg::CNT_SEQ_END) begin
          held_sequence <= {held_sequence[23:0], b};
        end else begin
          held_checksum <= checksum_shift;
        end
        if (hdr_done) begin
          running_sum     <= '0;
          bytes_remaining <= held_length;
        end
      end else if (phase == msd_pkg::PH_PAYLOAD) begin
        running_sum     <= sum_shift;
        bytes_remaining <= bytes_remaining - 32'd1;
      end
    end
  end

endmodule

/* hdl/msd_queue.sv */
// ----------------------------------------------------------------------------
// msd_queue
// Short result queue between parser and output; drives the result channel.
// ----------------------------------------------------------------------------
module msd_queue #(
  parameter int DEPTH = msd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msd_pkg::result_t push_data,
  output logic             full,
  msd_result_if.source     results
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msd_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic             do_push;
  msd_pkg::result_t head;

  assign full    = count == CNT_W'(DEPTH);
  assign pop     = results.valid && results.ready;
  assign do_push = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head                    = mem[rd_ptr];
  assign results.valid           = count != '0;
  assign results.is_header       = head.is_header;
  assign results.msg_type        = head.msg_type;
  assign results.sequence_number = head.sequence_number;
  assign results.payload_length  = head.payload_length;
  assign results.payload_byte    = head.payload_byte;
  assign results.last            = head.last;
  assign results.checksum_ok     = head.checksum_ok;

endmodule

/* hdl/magic_sync_message_deframer.sv */
// ----------------------------------------------------------------------------
// magic_sync_message_deframer
// A result beat is queued as its byte is accepted, then presented at the head.
// Throughput: one byte per cycle; the parser takes a byte whenever the result
// queue (QUEUE_DEPTH entries) has room, so the output may stall on its own.
// Reset (rst, synchronous): hunting with an empty window, queue empty,
// magic_word 0, max_payload_length 65536. No clearing pass.
// ----------------------------------------------------------------------------
module magic_sync_message_deframer #(
  parameter int QUEUE_DEPTH = msd_pkg::QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  msd_cfg_if.sink      cfg,
  msd_byte_if.sink     stream,
  msd_result_if.source results
);

  logic             push;
  logic             full;
  msd_pkg::result_t push_data;

  msd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stream     (stream),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  msd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .results   (results)
  );

endmodule

/* hdl/msd_checker.sv */
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks on the deframer result channel.
// ----------------------------------------------------------------------------
module msd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_header,
  input logic [7:0]  payload_byte,
  input logic        last,
  input logic        checksum_ok
);

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
    $stable(is_header) && $stable(last) && $stable(checksum_ok))
    else $error("result beat changed while stalled");

  a_header_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_header |-> payload_byte == 8'd0)
    else $error("header beat carries a payload byte");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !checksum_ok)
    else $error("checksum verdict on a beat that is not last");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind magic_sync_message_deframer msd_checker u_msd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .is_header    (results.is_header),
  .payload_byte (results.payload_byte),
  .last         (results.last),
  .checksum_ok  (results.checksum_ok)
);

/* sim/magic_sync_message_deframer_tb.sv */
// ----------------------------------------------------------------------------
// magic_sync_message_deframer_tb
// Streams framed and unframed bytes into the deframer through several register
// settings. A software deframer or a typed row gives each result beat, and the
// beats are compared field by field. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module magic_sync_message_deframer_tb;
  import msd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 160;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = CFG_MAX_PAYLOAD + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = '1;

  typedef struct {
    logic [7:0] data;
    bit         typed;
    result_t    result;
  } stim_row_t;

  // empty message with all-ones type and sequence, zero checksum
  localparam result_t EMPTY_MSG_HDR = '{
    is_header: 1'b1, msg_type: 32'hFFFF_FFFF, sequence_number: 32'hFFFF_FFFF,
    payload_length: 32'h0, payload_byte: 8'h00, last: 1'b1, checksum_ok: 1'b1
  };

  // reset magic is zero: three zeros must not match, the fourth does
  stim_row_t directed_rows [24] = '{
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, EMPTY_MSG_HDR},
    '{8'h5A, 1'b0, '0}, '{8'hA5, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}
  };

  logic clk;
  logic rst;

  msd_cfg_if    cfg_ch ();
  msd_byte_if   byte_ch ();
  msd_result_if res_ch ();

  magic_sync_message_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .stream  (byte_ch),
    .results (res_ch)
  );

  // deframer state as predicted
  logic [31:0] cfg_magic = 32'h0;
  logic [31:0] cfg_max   = MAX_PAYLOAD_RESET;
  phase_t      hunt_phase = PH_HUNT;
  logic [31:0] window     = '0;
  logic [4:0]  hdr_count  = '0;
  logic [31:0] h_type = '0, h_len = '0, h_seq = '0, h_sum = '0;
  logic [31:0] byte_sum = '0, remaining = '0;

  result_t   awaited_results [$];
  stim_row_t sent_notes [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        idle_pct = 0;
  int        stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void restart_hunt();
    hunt_phase = PH_HUNT;
    window     = '0;
    hdr_count  = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [4:0] idx;
    bit         made;
    logic       hdr, lst, ok;
    logic [7:0] pb;
    made = 1'b0;
    hdr  = 1'b0;
    lst  = 1'b0;
    ok   = 1'b0;
    pb   = 8'h00;
    case (hunt_phase)
      PH_HEADER: begin
        idx = hdr_count;
        if (idx < CNT_TYPE_END) h_type = {h_type[23:0], b};
        else if (idx < CNT_LEN_END) h_len = {h_len[23:0], b};
        else if (idx < CNT_SEQ_END) h_seq = {h_seq[23:0], b};
        else h_sum = {h_sum[23:0], b};
        hdr_count = idx + 1'b1;
        if (hdr_count == HEADER_BYTES) begin
          if (h_len > cfg_max) begin
            restart_hunt();
          end else if (h_len == 0) begin
            made = 1'b1;
            hdr  = 1'b1;
            lst  = 1'b1;
            ok   = (h_sum == 0);
            restart_hunt();
          end else begin
            made       = 1'b1;
            hdr        = 1'b1;
            hunt_phase = PH_PAYLOAD;
            byte_sum   = '0;
            remaining  = h_len;
          end
        end
      end
      PH_PAYLOAD: begin
        byte_sum  = byte_sum + b;
        remaining = remaining - 1;
        made = 1'b1;
        pb   = b;
        if (remaining == 0) begin
          lst = 1'b1;
          ok  = (byte_sum == h_sum);
          restart_hunt();
        end
      end
      default: begin
        if (hunt_phase != PH_HUNT) restart_hunt();
        window = {window[23:0], b};
        if (hdr_count < MAGIC_BYTES) hdr_count = hdr_count + 1'b1;
        if (hdr_count >= MAGIC_BYTES && window == cfg_magic) begin
          hunt_phase = PH_HEADER;
          hdr_count  = CNT_MAGIC;
          h_type = '0;
          h_len  = '0;
          h_seq  = '0;
          h_sum  = '0;
        end
      end
    endcase
    r.is_header       = hdr;
    r.msg_type        = h_type;
    r.sequence_number = h_seq;
    r.payload_length  = h_len;
    r.payload_byte    = pb;
    r.last            = lst;
    r.checksum_ok     = ok;
    return made;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    stim_row_t note;
    result_t   predicted;
    result_t   seen;
    result_t   want;
    bit        made;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MAGIC_WORD:  cfg_magic = cfg_ch.data;
          CFG_MAX_PAYLOAD: cfg_max   = cfg_ch.data;
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        seen.is_header       = res_ch.is_header;
        seen.msg_type        = res_ch.msg_type;
        seen.sequence_number = res_ch.sequence_number;
        seen.payload_length  = res_ch.payload_length;
        seen.payload_byte    = res_ch.payload_byte;
        seen.last            = res_ch.last;
        seen.checksum_ok     = res_ch.checksum_ok;
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("is_header", 32'(want.is_header), 32'(seen.is_header));
          check_field("msg_type", want.msg_type, seen.msg_type);
          check_field("sequence_number", want.sequence_number, seen.sequence_number);
          check_field("payload_length", want.payload_length, seen.payload_length);
          check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
          check_field("last", 32'(want.last), 32'(seen.last));
          check_field("checksum_ok", 32'(want.checksum_ok), 32'(seen.checksum_ok));
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        note = sent_notes.pop_front();
        made = deframe_byte(byte_ch.data_byte, predicted);
        if (note.typed) awaited_results = {awaited_results, note.result};
        else if (made) awaited_results = {awaited_results, predicted};
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure, in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // entered at a falling edge; leaves valid high after the beat is taken
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    stim_row_t note;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    note.data   = b;
    note.typed  = typed;
    note.result = want;
    sent_notes  = {sent_notes, note};
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic push_word(ref logic [7:0] q [$], input logic [31:0] w);
    q = {q, w[31:24], w[23:16], w[15:8], w[7:0]};
  endtask

  initial begin : stimulus
    logic [31:0] cur_magic, cur_max, len, ptype, csum, sum;
    logic [7:0]  frame_q [$];
    logic [7:0]  pbyte;
    int          used, frames, sel, k;
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    res_ch.ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 25;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].result);
    drain_results();

    cur_magic = 32'h0;
    cur_max   = MAX_PAYLOAD_RESET;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        case (ph)
          1: begin cur_magic = $urandom; cur_max = 32'h0; end
          2: begin cur_magic = 32'hFFFF_FFFF; cur_max = 32'd8; end
          3: begin cur_magic = $urandom; cur_max = 32'hFFFF_FFFF; end
          4: begin cur_magic = $urandom; cur_max = $urandom_range(1, 12); end
          5: begin cur_magic = 32'h0; cur_max = 32'd5; end
          6: begin cur_magic = $urandom; cur_max = 32'd12; end
          default: begin cur_magic = $urandom; cur_max = $urandom_range(0, 12); end
        endcase
        write_reg(CFG_MAGIC_WORD, cur_magic);
        write_reg(CFG_MAX_PAYLOAD, cur_max);
        if (ph == 4) begin
          write_reg(CFG_UNUSED_LO, $urandom);
          write_reg(CFG_UNUSED_HI, $urandom);
        end
        cfg_ch.valid <= 1'b0;
      end
      // no idling in two phases, the last of them closing the run
      idle_pct = (ph == 2 || ph == PHASES - 1) ? 0 : 25;
      used   = 0;
      frames = 0;
      while (used < PHASE_BYTES) begin
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0, '0);
        frame_q.delete();
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          // broken start word
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) frame_q = {frame_q, cur_magic[31 - 8*i -: 8]};
          frame_q = {frame_q, 8'($urandom)};
        end else begin
          sel = $urandom_range(0, 7);
          if (sel == 0) len = 32'h0;
          else if (sel == 1 && cur_max <= 12) len = cur_max;
          else if (sel == 2 && cur_max != 32'hFFFF_FFFF)
            len = $urandom_range(0, 1) ? cur_max + 1 : 32'hFFFF_FFFF;
          else len = $urandom_range(1, 12);
          // a start word inside the type field must not restart a dropped header
          ptype = ($urandom_range(0, 3) == 0) ? cur_magic : $urandom;
          sum = '0;
          push_word(frame_q, cur_magic);
          push_word(frame_q, ptype);
          push_word(frame_q, len);
          push_word(frame_q, $urandom);
          k = frame_q.size();
          push_word(frame_q, 32'h0);
          if (len <= cur_max) begin
            for (int i = 0; i < len; i++) begin
              pbyte   = 8'($urandom);
              sum     = sum + pbyte;
              frame_q = {frame_q, pbyte};
            end
          end
          csum = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) ? sum + 1 : $urandom))
                                             : sum;
          for (int i = 0; i < 4; i++) frame_q[k + i] = csum[31 - 8*i -: 8];
        end
        foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, '0);
        used += frame_q.size();
        frames++;
        if (ph == 3 && frames == 2) drain_results();
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* magic_sync_message_deframer.f */
hdl/msd_pkg.sv
hdl/msd_ifs.sv
hdl/msd_front.sv
hdl/msd_queue.sv
hdl/magic_sync_message_deframer.sv
hdl/msd_checker.sv
sim/magic_sync_message_deframer_tb.sv
